[rtl/core/hsi_to_rgbw_converter_macros.svh]
`ifndef HSI_TO_RGBW_CONVERTER_MACROS_SVH
`define HSI_TO_RGBW_CONVERTER_MACROS_SVH

// same-cycle implication, reset masks the check
`define HSIRGBW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSIRGBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hsirgbw_pkg.sv]
`default_nettype none

package hsirgbw_pkg;

    localparam int HUE_W    = 16;
    localparam int IN_W     = 18;   // signed Q1.16 saturation / intensity
    localparam int UNIT_W   = 17;   // clamped 0..65536
    localparam int ENTRY_W  = 18;   // ratio entry, Q2.16, 0..196608
    localparam int LEVEL_W  = 10;

    localparam logic [UNIT_W-1:0]  ONE_Q16    = 17'd65536;
    localparam logic [ENTRY_W-1:0] THREE_Q16  = 18'd196608;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 10'd1023;

    localparam longint unsigned SECTOR_Q28   = 64'd562209904;  // 2*pi/3
    localparam longint unsigned THIRD_PI_Q28 = 64'd281104952;  // pi/3

    // 16-bit reciprocal of 3, exact for values under 2^12
    localparam logic [15:0] RECIP3_Q17 = 16'd43691;

    // sector codes, from hue*3 >> 16
    localparam logic [1:0] SEC_RG = 2'd0;
    localparam logic [1:0] SEC_GB = 2'd1;
    localparam logic [1:0] SEC_BR = 2'd2;

    typedef logic [UNIT_W-1:0]  unit_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // restoring long division, truncating; elaboration use only
    function automatic longint unsigned udiv_const(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q28 cosine, Taylor series through the x^24 term; elaboration use only
    function automatic longint cos_q28(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned dv;
        longint          sum;
        x2   = (x * x) >> 28;
        term = 64'd1 << 28;
        sum  = longint'(term);
        for (int n = 1; n <= 12; n++)
        begin
            dv   = 64'((2 * n - 1) * (2 * n));
            term = udiv_const((term * x2) >> 28, dv);
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

[rtl/core/hsi_to_rgbw_converter.sv]
`default_nettype none

// channel   dir  bits  fields (lsb first)
// s_axis    in   56    hue[15:0], saturation[33:16], intensity[51:34], pad
// m_axis    out  40    red[9:0], green[19:10], blue[29:20], white[39:30]
//
// Five register stages: clamp/sector/index, ratio ROM read and s*i products,
// ratio multiplies, *1023 scaling, divide-by-3 and channel select.
// One request per clock unless the output stalls; m_axis_tvalid is the stage-5 valid bit.
// Stalls freeze the whole pipe; s_axis_tready follows a free or draining output.
// rst_n clears only the stage valid bits; the ratio ROM is constant.
module hsi_to_rgbw_converter #(
    parameter int RATIO_TABLE_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // hue, saturation, intensity, zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // red, green, blue, white
);
    import hsirgbw_pkg::*;

    localparam int IDX_W   = $clog2(RATIO_TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(RATIO_TABLE_DEPTH + 1);
    localparam int PROD_W  = HUE_W + DEPTH_W;

    typedef entry_t rom_t [RATIO_TABLE_DEPTH];

    // 1 + cos(h)/cos(60deg - h), h spanning one 120-degree sector
    function automatic entry_t ratio_entry(input int k);
        longint unsigned h;
        longint unsigned d;
        longint          ch;
        longint          cd;
        longint          num;
        longint          q;
        longint          e;
        h  = (longint'(k) * SECTOR_Q28) / RATIO_TABLE_DEPTH;
        d  = (h > THIRD_PI_Q28) ? h - THIRD_PI_Q28 : THIRD_PI_Q28 - h;
        ch = cos_q28(h);
        cd = cos_q28(d);
        if (cd <= 0)
            cd = 1;
        // quotient truncates toward zero
        num = ch * 65536;
        if (num < 0)
            q = -longint'(udiv_const(unsigned'(-num), unsigned'(cd)));
        else
            q = longint'(udiv_const(unsigned'(num), unsigned'(cd)));
        e = 65536 + q;
        if (e < 0)
            e = 0;
        if (e > 196608)
            e = 196608;
        return ENTRY_W'(e);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < RATIO_TABLE_DEPTH; k++)
        begin
            r[k] = ratio_entry(k);
        end
        return r;
    endfunction

    localparam rom_t RATIO_ROM = build_rom();

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1 inputs
    logic [HUE_W-1:0]  hue;
    logic [IN_W-1:0]   sat_raw;
    logic [IN_W-1:0]   int_raw;
    unit_t             s_next, i_next;
    logic [HUE_W+1:0]  hue3;
    logic [PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]  idx_next;

    logic [1:0]        sec1_reg, sec2_reg, sec3_reg, sec4_reg;
    unit_t             s1_reg, i1_reg;
    logic [IDX_W-1:0]  idx1_reg;

    entry_t            f2_reg;
    logic [32:0]       p2_reg;
    logic [32:0]       w2_reg;

    logic [49:0]       ql3_reg, qt3_reg;
    level_t            white3_reg, white4_reg;
    logic [42:0]       w_scaled;
    logic [10:0]       white_next;

    logic [59:0]       rl_scaled, rt_scaled;
    logic [11:0]       xl4_reg, xt4_reg;

    logic [27:0]       dl_prod, dt_prod;
    level_t            lead_next, trail_next;
    level_t            red_next, green_next, blue_next;
    level_t            red_reg, green_reg, blue_reg, white_reg;

    assign en            = !v5_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {white_reg, blue_reg, green_reg, red_reg};

    // stage 1: clamp to [0,1], split hue into sector and ROM index
    always_comb
    begin
        hue     = s_axis_tdata[15:0];
        sat_raw = s_axis_tdata[33:16];
        int_raw = s_axis_tdata[51:34];

        if (sat_raw[IN_W-1])
            s_next = '0;
        else if (sat_raw[UNIT_W-1:0] > ONE_Q16)
            s_next = ONE_Q16;
        else
            s_next = sat_raw[UNIT_W-1:0];

        if (int_raw[IN_W-1])
            i_next = '0;
        else if (int_raw[UNIT_W-1:0] > ONE_Q16)
            i_next = ONE_Q16;
        else
            i_next = int_raw[UNIT_W-1:0];

        hue3     = {hue, 1'b0} + {2'b00, hue};
        idx_prod = PROD_W'(hue3[HUE_W-1:0]) * PROD_W'(RATIO_TABLE_DEPTH);
        idx_next = idx_prod[HUE_W +: IDX_W];
    end

    // stage 3: white scaling, (w << 10) - w then >> 32
    always_comb
    begin
        w_scaled   = {w2_reg, 10'b0} - {10'b0, w2_reg};
        white_next = w_scaled[42:32];
    end

    // stage 4: *1023 then drop 48 fraction bits
    always_comb
    begin
        rl_scaled = {ql3_reg, 10'b0} - {10'b0, ql3_reg};
        rt_scaled = {qt3_reg, 10'b0} - {10'b0, qt3_reg};
    end

    // stage 5: /3 by reciprocal, cap, route lead/trail by sector
    always_comb
    begin
        dl_prod    = 28'(xl4_reg) * 28'(RECIP3_Q17);
        dt_prod    = 28'(xt4_reg) * 28'(RECIP3_Q17);
        lead_next  = (dl_prod[27:17] > 11'(FULL_LEVEL)) ? FULL_LEVEL : dl_prod[26:17];
        trail_next = (dt_prod[27:17] > 11'(FULL_LEVEL)) ? FULL_LEVEL : dt_prod[26:17];

        unique case (sec4_reg)
            SEC_RG:
            begin
                red_next   = lead_next;
                green_next = trail_next;
                blue_next  = '0;
            end
            SEC_GB:
            begin
                red_next   = '0;
                green_next = lead_next;
                blue_next  = trail_next;
            end
            default:
            begin
                red_next   = trail_next;
                green_next = '0;
                blue_next  = lead_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec1_reg   <= hue3[HUE_W+1:HUE_W];
            s1_reg     <= s_next;
            i1_reg     <= i_next;
            idx1_reg   <= idx_next;

            f2_reg     <= RATIO_ROM[idx1_reg];
            p2_reg     <= 33'(s1_reg) * 33'(i1_reg);
            w2_reg     <= 33'(ONE_Q16 - s1_reg) * 33'(i1_reg);
            sec2_reg   <= sec1_reg;

            ql3_reg    <= 50'(p2_reg) * 50'(f2_reg);
            qt3_reg    <= 50'(p2_reg) * 50'(THREE_Q16 - f2_reg);
            white3_reg <= (white_next > 11'(FULL_LEVEL)) ? FULL_LEVEL : white_next[9:0];
            sec3_reg   <= sec2_reg;

            xl4_reg    <= rl_scaled[59:48];
            xt4_reg    <= rt_scaled[59:48];
            white4_reg <= white3_reg;
            sec4_reg   <= sec3_reg;

            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            white_reg  <= white4_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hsirgbw_checker.sv]
`default_nettype none

`include "hsi_to_rgbw_converter_macros.svh"

module hsirgbw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    import hsirgbw_pkg::*;

    logic [LEVEL_W+1:0] level_sum;

    // lead + trail + white never exceeds full scale
    assign level_sum = (LEVEL_W+2)'(m_axis_tdata[9:0]) + (LEVEL_W+2)'(m_axis_tdata[19:10])
                     + (LEVEL_W+2)'(m_axis_tdata[29:20]) + (LEVEL_W+2)'(m_axis_tdata[39:30]);

    `HSIRGBW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output request changed while stalled")

    `HSIRGBW_ASSERT_NOW(a_one_dark, clk, rst_n, m_axis_tvalid, m_axis_tdata[9:0] == '0 || m_axis_tdata[19:10] == '0 || m_axis_tdata[29:20] == '0, "no color channel is zero")

    `HSIRGBW_ASSERT_NOW(a_level_sum, clk, rst_n, m_axis_tvalid, level_sum <= (LEVEL_W+2)'(FULL_LEVEL), "sum of drive levels above full scale")

    `HSIRGBW_ASSERT_NOW(a_stall_blocks, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while pipe is stalled")

endmodule

bind hsi_to_rgbw_converter hsirgbw_checker u_hsirgbw_checker (.*);

`default_nettype wire
